// File: rtl/kfb_pkg.sv
package kfb_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = BYTE_W + 2;
  localparam int unsigned SLOTS     = 3;
  localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hff;
  localparam logic [LEN_W-1:0]  LEN_EXTRA = 10'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              is_type;
    logic              part_last;
    logic [BYTE_W-1:0] data_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_last;
    logic              length_error;
  } out_item_t;

  // Bytes caused by one request, oldest in slot 0; n is 1 to 3.
  typedef struct packed {
    out_item_t [SLOTS-1:0] slot;
    logic [1:0]            n;
  } entry_t;

endpackage

// File: rtl/kfb_front.sv
module kfb_front
  import kfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t req,
  output entry_t   entry
);

  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] tcnt_r, tcnt_nxt;
  logic              in_data_r, in_data_nxt;
  logic              len_err_r, len_err_nxt;

  logic [BYTE_W-1:0] sum_a, sum_b, tcnt_inc, cs_len, cs_data;
  logic [LEN_W-1:0]  total;
  logic              total_err, zero_data;

  always_comb begin
    sum_a     = sum_r + req.in_byte;
    tcnt_inc  = (tcnt_r == BYTE_MAX) ? tcnt_r : tcnt_r + 8'd1;
    total     = LEN_EXTRA + {2'b00, tcnt_inc} + {2'b00, req.data_count};
    total_err = (total[LEN_W-1:BYTE_W] != 2'b00);
    sum_b     = sum_a + total[BYTE_W-1:0];
    cs_len    = 8'h00 - sum_b;
    cs_data   = 8'h00 - sum_a;
    zero_data = (req.data_count == 8'h00);
  end

  always_comb begin
    entry       = '0;
    sum_nxt     = sum_r;
    tcnt_nxt    = tcnt_r;
    in_data_nxt = in_data_r;
    len_err_nxt = len_err_r;
    if (!in_data_r) begin
      entry.slot[0] = '{out_byte: req.in_byte, frame_last: 1'b0, length_error: 1'b0};
      entry.n       = 2'd1;
      sum_nxt       = sum_a;
      tcnt_nxt      = tcnt_inc;
      if (req.part_last) begin
        entry.slot[1] = '{out_byte: total[BYTE_W-1:0], frame_last: 1'b0,
                          length_error: total_err};
        entry.n       = 2'd2;
        sum_nxt       = sum_b;
        len_err_nxt   = total_err;
        in_data_nxt   = 1'b1;
        if (zero_data) begin
          entry.slot[2] = '{out_byte: cs_len, frame_last: 1'b1, length_error: total_err};
          entry.n       = 2'd3;
          sum_nxt       = '0;
          tcnt_nxt      = '0;
          len_err_nxt   = 1'b0;
          in_data_nxt   = 1'b0;
        end
      end
    end else begin
      entry.slot[0] = '{out_byte: req.in_byte, frame_last: 1'b0, length_error: len_err_r};
      entry.n       = 2'd1;
      sum_nxt       = sum_a;
      if (req.part_last) begin
        entry.slot[1] = '{out_byte: cs_data, frame_last: 1'b1, length_error: len_err_r};
        entry.n       = 2'd2;
        sum_nxt       = '0;
        tcnt_nxt      = '0;
        len_err_nxt   = 1'b0;
        in_data_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      tcnt_r    <= '0;
      in_data_r <= 1'b0;
      len_err_r <= 1'b0;
    end else if (accept) begin
      sum_r     <= sum_nxt;
      tcnt_r    <= tcnt_nxt;
      in_data_r <= in_data_nxt;
      len_err_r <= len_err_nxt;
    end
  end

endmodule

// File: rtl/kfb_fifo.sv
module kfb_fifo
  import kfb_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_data,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/kfb_back.sv
module kfb_back
  import kfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    q_data,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  entry_t     cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       take, at_end, load;

  assign empty    = !cur_valid_r;
  assign out_data = cur_r.slot[idx_r];
  assign take     = pop && cur_valid_r;
  assign at_end   = (idx_r == cur_r.n - 2'd1);
  assign load     = !cur_valid_r || (take && at_end);
  assign q_pop    = load && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      cur_valid_r <= !q_empty;
      idx_r       <= '0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.n != 2'd0))
    else $error("held entry carries no bytes");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r < cur_r.n))
    else $error("byte index beyond entry");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && out_data.frame_last) |-> at_end)
    else $error("frame end flagged before last byte of entry");

  a_step_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !at_end) |=> (cur_valid_r && idx_r == $past(idx_r) + 2'd1))
    else $error("index did not advance after request taken");

endmodule

// File: rtl/kline_frame_builder.sv
// Channel  Ports                      Request moves on
// -------  -------------------------  -----------------------
// input    push, full, in_data        push && !full
// result   empty, pop, out_data       pop && !empty
//
// Each input request is classified combinationally and yields one to three frame bytes
// (one, or two with length or checksum, or three for length plus checksum).
// The result side delivers one byte per cycle while pop is high and bytes wait, so a
// request with k bytes holds it until all are taken; the queue of QUEUE_DEPTH entries
// absorbs this. An accepted request goes through the queue and hold register to out_data.
// Reset (sync, active low) clears queue and frame; full rises only with the queue full.
module kline_frame_builder
  import kfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  entry_t front_entry, q_data;
  logic   accept, q_empty, q_pop;

  assign accept = push && !full;

  kfb_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_data),
    .entry  (front_entry)
  );

  kfb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (front_entry),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  kfb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// File: verif/tb_kline_frame_builder.sv
module tb_kline_frame_builder;
  import kfb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RX_LONG_HOLD   = 60;

  typedef struct packed {
    in_item_t req;
    logic     drain_first;
  } stim_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_data;

  stim_t     stim[$];
  out_item_t frame_bytes_due[$];

  // frame state of the predictor
  logic [BYTE_W-1:0] frame_sum = '0;
  logic [BYTE_W-1:0] types_seen = '0;
  logic              data_part = 1'b0;
  logic              len_over = 1'b0;

  int n_predicted = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_total = 1;
  int errors = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  int quiet_cycles = 0;
  bit long_hold_done = 1'b0;
  stim_t     next_req;
  out_item_t want;

  logic late;
  logic calm;
  assign late = n_sent >= n_total - n_total / 10;
  assign calm = ((n_sent / 45) % 3) == 2;

  kline_frame_builder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void push_due(logic [BYTE_W-1:0] b, logic last, logic err);
    frame_bytes_due.push_back('{out_byte: b, frame_last: last, length_error: err});
    n_predicted++;
  endfunction

  function automatic void close_frame();
    push_due(~frame_sum + 8'd1, 1'b1, len_over);
    frame_sum  = '0;
    types_seen = '0;
    data_part  = 1'b0;
    len_over   = 1'b0;
  endfunction

  // Frame bytes caused by one accepted request.
  function automatic void build_frame_bytes(in_item_t r);
    logic [LEN_W-1:0] total;
    frame_sum = frame_sum + r.in_byte;
    if (!data_part) begin
      push_due(r.in_byte, 1'b0, 1'b0);
      if (types_seen != BYTE_MAX) types_seen = types_seen + 8'd1;
      if (!r.part_last) return;
      total = LEN_EXTRA + LEN_W'(types_seen) + LEN_W'(r.data_count);
      len_over = total > LEN_W'(BYTE_MAX);
      frame_sum = frame_sum + total[BYTE_W-1:0];
      push_due(total[BYTE_W-1:0], 1'b0, len_over);
      if (r.data_count == '0) close_frame();
      else data_part = 1'b1;
    end else begin
      push_due(r.in_byte, 1'b0, len_over);
      if (r.part_last) close_frame();
    end
  endfunction

  // fixed_byte < 0 gives random bytes; noisy sets is_type at random
  task automatic queue_frame(input int n_types, input int dcount, input int n_data,
                             input int fixed_byte, input bit drain, input bit noisy);
    stim_t s;
    for (int i = 0; i < n_types; i++) begin
      s.req.in_byte    = (fixed_byte < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fixed_byte);
      s.req.is_type    = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
      s.req.part_last  = (i == n_types - 1);
      s.req.data_count = (i == n_types - 1) ? BYTE_W'(dcount) : BYTE_W'($urandom_range(0, 255));
      s.drain_first    = drain && (i == 0);
      stim.push_back(s);
    end
    if (dcount == 0) return;
    for (int i = 0; i < n_data; i++) begin
      s.req.in_byte    = (fixed_byte < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fixed_byte);
      s.req.is_type    = noisy ? 1'($urandom_range(0, 1)) : 1'b0;
      s.req.part_last  = (i == n_data - 1);
      s.req.data_count = BYTE_W'($urandom_range(0, 255));
      s.drain_first    = 1'b0;
      stim.push_back(s);
    end
  endtask

  initial begin
    int nt;
    int dc;
    int nd;
    int r;
    queue_frame(1, 0, 0, 8'h00, 1'b0, 1'b0);
    queue_frame(1, 0, 0, 8'hff, 1'b0, 1'b0);
    queue_frame(2, 3, 3, 8'hff, 1'b0, 1'b1);
    queue_frame(1, 253, 2, -1, 1'b0, 1'b0);
    queue_frame(3, 255, 1, 8'h00, 1'b0, 1'b1);
    queue_frame(1, 252, 1, -1, 1'b0, 1'b0);
    queue_frame(2, 2, 2, 8'h80, 1'b1, 1'b0);
    queue_frame(3, 1, 4, 8'h7f, 1'b0, 1'b0);
    // type count saturates
    queue_frame(257, 5, 2, -1, 1'b1, 1'b0);
    while (stim.size() < 310) begin
      r  = $urandom_range(0, 9);
      nt = (r == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      if (r < 6) begin
        dc = $urandom_range(0, 6);
        nd = dc;
      end else if (r < 8) begin
        dc = $urandom_range(0, 255);
        nd = $urandom_range(1, 5);
      end else begin
        dc = $urandom_range(1, 8);
        nd = $urandom_range(1, 10);
      end
      queue_frame(nt, dc, nd, -1, $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
    end
    n_total = stim.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (stim.size() != 0 || push) @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      errors++;
      $display("%0t: %0d frame bytes never arrived", $time, frame_bytes_due.size());
    end
    if (errors == 0) begin
      $display("tb_kline_frame_builder: clean");
    end else begin
      $display("tb_kline_frame_builder: errors");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        build_frame_bytes(in_data);
        n_sent <= n_sent + 1;
      end
      if (!(push && full)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (stim.size() == 0) begin
          push <= 1'b0;
        end else if (stim[0].drain_first && n_predicted != n_got) begin
          push <= 1'b0;
        end else if (!late && !calm && $urandom_range(0, 4) == 0) begin
          tx_gap = $urandom_range(0, 10);
          push <= 1'b0;
        end else begin
          next_req = stim.pop_front();
          in_data <= next_req.req;
          push <= 1'b1;
        end
      end
    end
  end

  // result monitor and pop control
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_got <= n_got + 1;
        if (frame_bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte, got %h/%b/%b", $time,
                   out_data.out_byte, out_data.frame_last, out_data.length_error);
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.frame_last !== want.frame_last ||
              out_data.length_error !== want.length_error) begin
            errors++;
            $display("%0t: byte mismatch, expected %h/%b/%b got %h/%b/%b", $time,
                     want.out_byte, want.frame_last, want.length_error,
                     out_data.out_byte, out_data.frame_last, out_data.length_error);
          end
        end
      end
      if (!long_hold_done && n_got == 40) begin
        long_hold_done = 1'b1;
        rx_stall = RX_LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else if (!late && !calm && $urandom_range(0, 4) == 0) begin
        rx_stall = $urandom_range(0, 10);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // no request moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_kline_frame_builder: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
